FILE: rtl/m4vt_pkg.sv
`default_nettype none

package m4vt_pkg;

  localparam int unsigned NCOMP     = 4;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = 2 * Q_W;
  // four full-width products summed without loss
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned NPAIRS    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;

  typedef logic signed [Q_W-1:0]    q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [CFG_W-1:0]         pair_t;

  typedef q16_t  [NCOMP-1:0] vec_t;
  typedef prod_t [NCOMP-1:0] prod_vec_t;
  typedef acc_t  [NCOMP-1:0] acc_vec_t;

  // payload handed from one cell to the next
  typedef struct packed {
    vec_t     vec;
    acc_vec_t acc;
  } cell_bus_t;

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
  localparam q16_t Q_MAX      = {1'b0, {(Q_W-1){1'b1}}};
  localparam q16_t Q_MIN      = {1'b1, {(Q_W-1){1'b0}}};

  // identity matrix, column-major, two elements per register
  localparam pair_t [NPAIRS-1:0] COEF_RESET = {
    64'h0001_0000_0000_0000,  // pair 7
    64'h0000_0000_0000_0000,  // pair 6
    64'h0000_0000_0001_0000,  // pair 5
    64'h0000_0000_0000_0000,  // pair 4
    64'h0000_0000_0000_0000,  // pair 3
    64'h0001_0000_0000_0000,  // pair 2
    64'h0000_0000_0000_0000,  // pair 1
    64'h0000_0000_0001_0000   // pair 0
  };

endpackage

`default_nettype wire

FILE: rtl/matrix4_vector_transform.sv
// pipeline: two registers per column cell, then one for rounding and saturation
// throughput: one vector per cycle while out_tready is high; the cells advance independently under stall
// reset: rst_n is synchronous, active low; it empties the pipeline and loads
//   the identity matrix into the coefficient registers
`default_nettype none

module matrix4_vector_transform import m4vt_pkg::*; #(
  parameter int unsigned DIM = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [127:0]         in_tdata,   // x_in, y_in, z_in, w_in
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [127:0]              out_tdata,  // x_out, y_out, z_out, w_out
  output logic                      out_tuser,  // saturated
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  pair_t [NPAIRS-1:0] coef_r;

  logic      [DIM:0] vld;
  logic      [DIM:0] rdy;
  cell_bus_t [DIM:0] bus;
  acc_vec_t          acc_final;
  vec_t              res_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  assign vld[0]     = in_tvalid;
  assign in_tready  = rdy[0];
  assign bus[0].vec = in_tdata;
  assign bus[0].acc = '0;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    vec_t col;
    // column c: rows 0,1 in pair 2c, rows 2,3 in pair 2c+1
    assign col = {coef_r[2*c+1], coef_r[2*c]};

    m4vt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .coef_col  (col),
      .in_valid  (vld[c]),
      .in_ready  (rdy[c]),
      .in_bus    (bus[c]),
      .out_valid (vld[c+1]),
      .out_ready (rdy[c+1]),
      .out_bus   (bus[c+1])
    );
  end

  // rows outside the active dimension read as zero
  for (genvar r = 0; r < NCOMP; r++) begin : g_row
    if (r < DIM) begin : g_on
      assign acc_final[r] = bus[DIM].acc[r];
    end else begin : g_off
      assign acc_final[r] = '0;
    end
  end

  m4vt_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld[DIM]),
    .in_ready  (rdy[DIM]),
    .in_acc    (acc_final),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vec   (res_vec),
    .out_sat   (out_tuser)
  );

  assign out_tdata = res_vec;

endmodule

`default_nettype wire

FILE: rtl/m4vt_cell.sv
`default_nettype none

module m4vt_cell import m4vt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire vec_t      coef_col,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cell_bus_t in_bus,
  output logic           out_valid,
  input  wire logic      out_ready,
  output cell_bus_t      out_bus
);

  logic      va_r, vb_r;
  logic      rdy_a, rdy_b;
  prod_vec_t prod_r, prod_nxt;
  acc_vec_t  acc_a_r;
  vec_t      vec_a_r, vec_nxt;
  cell_bus_t bus_b_r, bus_b_nxt;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // this cell takes component 0, the rest move down one place
  always_comb begin
    vec_nxt = {q16_t'(0), in_bus.vec[NCOMP-1:1]};
    for (int r = 0; r < NCOMP; r++) begin
      prod_nxt[r] = prod_t'(coef_col[r]) * prod_t'(in_bus.vec[0]);
    end
  end

  always_comb begin
    bus_b_nxt.vec = vec_a_r;
    for (int r = 0; r < NCOMP; r++) begin
      bus_b_nxt.acc[r] = acc_a_r[r] + acc_t'($signed(prod_r[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod_r  <= prod_nxt;
      acc_a_r <= in_bus.acc;
      vec_a_r <= vec_nxt;
    end
    if (rdy_b) begin
      bus_b_r <= bus_b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_bus   = bus_b_r;

endmodule

`default_nettype wire

FILE: rtl/m4vt_round.sv
`default_nettype none

module m4vt_round import m4vt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire acc_vec_t in_acc,
  output logic          out_valid,
  input  wire logic     out_ready,
  output vec_t          out_vec,
  output logic          out_sat
);

  logic valid_r;
  vec_t vec_r, vec_nxt;
  logic sat_r, sat_nxt;
  acc_t rounded;

  assign in_ready = !valid_r || out_ready;

  // round half up, then clamp when the bits above q16.16 are not all sign
  always_comb begin
    sat_nxt = 1'b0;
    rounded = '0;
    for (int r = 0; r < NCOMP; r++) begin
      rounded = in_acc[r] + ROUND_HALF;
      if ((&rounded[ACC_W-1:FRAC_W+Q_W-1]) || !(|rounded[ACC_W-1:FRAC_W+Q_W-1])) begin
        vec_nxt[r] = rounded[FRAC_W+Q_W-1:FRAC_W];
      end else begin
        vec_nxt[r] = rounded[ACC_W-1] ? Q_MIN : Q_MAX;
        sat_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      vec_r <= vec_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_sat   = sat_r;

endmodule

`default_nettype wire

FILE: rtl/m4vt_checker.sv
`default_nettype none

module m4vt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic         out_tuser
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a saturated result must show a clamped component
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[31:0] == 32'h7fffffff || out_tdata[31:0] == 32'h80000000 ||
       out_tdata[63:32] == 32'h7fffffff || out_tdata[63:32] == 32'h80000000 ||
       out_tdata[95:64] == 32'h7fffffff || out_tdata[95:64] == 32'h80000000 ||
       out_tdata[127:96] == 32'h7fffffff || out_tdata[127:96] == 32'h80000000))
    else $error("saturation flag without a clamped component");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: dv/tb_matrix4_vector_transform.sv
`timescale 1ns / 1ps

module tb_matrix4_vector_transform;
  import m4vt_pkg::*;

  localparam int unsigned DIM           = 4;
  localparam int unsigned SETTLE_CYCLES = 2 * DIM + 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned COEF_PAIR_0   = 0;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_HI      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_LO      = 32'h8000_0000;

  typedef enum int {VAL_FULL, VAL_SMALL, VAL_EXTREME} val_kind_t;

  typedef struct packed {
    logic         sat;
    logic [127:0] comps;
  } xform_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [127:0]         in_tdata   = '0;   // x_in, y_in, z_in, w_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [127:0]         out_tdata;         // x_out, y_out, z_out, w_out
  logic                 out_tuser;         // saturated
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // column-major copy of the matrix: element c*4+r is row r, column c
  logic [31:0]  coef [16];
  xform_t       expected_xforms [$];
  int unsigned  errors      = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left  = 0;
  bit           idle_on     = 1'b1;
  string        comp_names [4] = '{"x_out", "y_out", "z_out", "w_out"};

  matrix4_vector_transform #(.DIM(DIM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_xforms.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // downstream back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic xform_t transform_vector(input logic [127:0] vec);
    logic signed [65:0] acc;
    logic signed [65:0] biased;
    logic signed [49:0] rounded;
    xform_t             res;
    res = '0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      if (r < DIM) begin
        for (int c = 0; c < DIM; c++)
          acc += 66'(signed'(coef[c*4 + r])) * 66'(signed'(vec[c*32 +: 32]));
        // round half up, then clamp to q16.16
        biased  = acc + 66'sd32768;
        rounded = 50'(biased >>> 16);
        if (rounded > 50'sd2147483647) begin
          res.comps[r*32 +: 32] = Q_HI;
          res.sat = 1'b1;
        end else if (rounded < -50'sd2147483648) begin
          res.comps[r*32 +: 32] = Q_LO;
          res.sat = 1'b1;
        end else begin
          res.comps[r*32 +: 32] = rounded[31:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    xform_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_xforms.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h sat %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_xforms.pop_front();
        for (int r = 0; r < 4; r++) begin
          if (out_tdata[r*32 +: 32] !== want.comps[r*32 +: 32]) begin
            $display("%0t: %s expected %h actual %h", $time, comp_names[r],
                     want.comps[r*32 +: 32], out_tdata[r*32 +: 32]);
            errors++;
          end
        end
        if (out_tuser !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_tuser);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_q16(input val_kind_t kind);
    logic [31:0] pick [7];
    pick = '{Q_HI, Q_LO, 32'h0, 32'h1, 32'hFFFF_FFFF, Q_ONE, Q_NEG_ONE};
    case (kind)
      VAL_FULL:  return $urandom();
      VAL_SMALL: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default:   return pick[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic val_kind_t rand_kind();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3)
      return VAL_FULL;
    if (roll == 3)
      return VAL_EXTREME;
    return VAL_SMALL;
  endfunction

  function automatic logic [127:0] vec4(input logic [31:0] x, y, z, w);
    return {w, z, y, x};
  endfunction

  function automatic logic [127:0] rand_vector();
    return vec4(rand_q16(rand_kind()), rand_q16(rand_kind()),
                rand_q16(rand_kind()), rand_q16(rand_kind()));
  endfunction

  task automatic send_vector(input logic [127:0] vec);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom(), $urandom(), $urandom(), $urandom()};
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= vec;
    do @(posedge clk); while (!in_tready);
    expected_xforms.push_back(transform_vector(vec));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_xforms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only call while no request is in flight
  task automatic load_matrix(input logic [31:0] m [16]);
    for (int k = 0; k < NPAIRS; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(COEF_PAIR_0 + k);
      cfg_wdata <= {m[2*k+1], m[2*k]};
      @(posedge clk);
      coef[2*k]   = m[2*k];
      coef[2*k+1] = m[2*k+1];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_matrix(input val_kind_t kind, input bit mixed);
    logic [31:0] m [16];
    for (int i = 0; i < 16; i++)
      m[i] = rand_q16(mixed ? rand_kind() : kind);
    load_matrix(m);
  endtask

  task automatic test_reset_identity();
    send_vector('0);
    send_vector(vec4(Q_HI, Q_HI, Q_HI, Q_HI));
    send_vector(vec4(Q_LO, Q_LO, Q_LO, Q_LO));
    send_vector(vec4(Q_NEG_ONE, Q_ONE, 32'hFFFF_FFFF, 32'h1));
    send_vector({$urandom(), $urandom(), $urandom(), $urandom()});
  endtask

  // one-lsb diagonal puts each input into the discarded half of the product
  task automatic test_rounding();
    logic [31:0] m [16];
    for (int i = 0; i < 16; i++)
      m[i] = (i % 5 == 0) ? 32'h1 : 32'h0;
    wait_drained();
    load_matrix(m);
    send_vector(vec4(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_7FFF));
    send_vector(vec4(32'h0001_8000, 32'hFFFE_8000, 32'h0001_7FFF, Q_LO));
  endtask

  task automatic test_saturation();
    logic [31:0] m [16];
    wait_drained();
    for (int i = 0; i < 16; i++)
      m[i] = Q_HI;
    load_matrix(m);
    send_vector(vec4(Q_HI, Q_HI, Q_HI, Q_HI));
    send_vector(vec4(Q_LO, Q_LO, Q_LO, Q_LO));
    wait_drained();
    for (int i = 0; i < 16; i++)
      m[i] = Q_LO;
    load_matrix(m);
    send_vector(vec4(Q_LO, Q_LO, Q_LO, Q_LO));
    send_vector(vec4(Q_HI, Q_HI, Q_HI, Q_HI));
    // rows sitting on or one lsb past the clamp bounds
    wait_drained();
    for (int i = 0; i < 16; i++)
      m[i] = 32'h0;
    m[0]  = Q_ONE;
    m[4]  = Q_ONE;
    m[1]  = Q_ONE;
    m[10] = Q_NEG_ONE;
    m[15] = Q_ONE;
    load_matrix(m);
    send_vector(vec4(Q_HI, 32'h1, Q_LO, 32'h0));
    send_vector(vec4(Q_LO, 32'hFFFF_FFFF, Q_HI, Q_HI));
    send_vector(vec4(Q_HI, 32'h0, 32'h8000_0001, 32'h5));
    wait_drained();
    for (int i = 0; i < 16; i++)
      m[i] = 32'h0;
    load_matrix(m);
    send_vector({$urandom(), $urandom(), $urandom(), $urandom()});
  endtask

  task automatic test_random_transforms();
    val_kind_t kinds [6] = '{VAL_FULL, VAL_SMALL, VAL_SMALL, VAL_SMALL, VAL_EXTREME, VAL_FULL};
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      load_random_matrix(kinds[phase], phase == 2 || phase == 5);
      for (int i = 0; i < 130; i++) begin
        // hold off mid-stream until the pipe is empty
        if (phase == 2 && i == 65)
          wait_drained();
        send_vector(rand_vector());
      end
    end
  endtask

  // columns of a right-hand matrix give the columns of the product
  task automatic test_matrix_product();
    wait_drained();
    load_random_matrix(VAL_SMALL, 1'b0);
    for (int col = 0; col < 4; col++)
      send_vector(vec4(rand_q16(VAL_SMALL), rand_q16(VAL_SMALL),
                       rand_q16(VAL_SMALL), rand_q16(VAL_SMALL)));
  endtask

  task automatic test_back_to_back();
    wait_drained();
    idle_on = 1'b0;
    load_random_matrix(VAL_SMALL, 1'b1);
    for (int i = 0; i < 170; i++)
      send_vector(rand_vector());
  endtask

  initial begin
    // identity: diagonal elements 0, 5, 10, 15
    for (int i = 0; i < 16; i++)
      coef[i] = (i % 5 == 0) ? Q_ONE : 32'h0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_identity();
    test_rounding();
    test_saturation();
    test_random_transforms();
    test_matrix_product();
    test_back_to_back();
    wait_drained();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/m4vt_pkg.sv
rtl/m4vt_cell.sv
rtl/m4vt_round.sv
rtl/matrix4_vector_transform.sv
rtl/m4vt_checker.sv
dv/tb_matrix4_vector_transform.sv
